// ----- rtl/bounded_queue_server_scheduler_unit_assert.svh -----
// Assertion macros for the bounded queue server scheduler.
// Included by the top level; expects signals clk and rst_n in scope.
`ifndef BOUNDED_QUEUE_SERVER_SCHEDULER_UNIT_ASSERT_SVH
`define BOUNDED_QUEUE_SERVER_SCHEDULER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BQSSU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BQSSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bqssu_pkg.sv -----
// Shared types and constants for the bounded queue server scheduler.
// No dependencies; imported by the controller, datapath and top level.
package bqssu_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int TIME_W = 48;
  localparam int DUR_W  = 32;
  localparam int NUM_W  = 32;
  localparam int LIM_W  = 5;
  localparam logic [LIM_W-1:0] LIMIT_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_COMPLETED  = 2'd0,
    ST_REJECTED   = 2'd1,
    ST_QUEUED     = 2'd2,
    ST_FLUSH_DONE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_POP,
    S_FINAL
  } fsm_state_t;

  typedef struct packed {
    logic [TIME_W-1:0] arrival;
    logic [DUR_W-1:0]  duration;
    logic [NUM_W-1:0]  number;
  } wait_entry_t;

  typedef struct packed {
    logic    load;
    logic    pop;
    logic    fin;
    status_t kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_flush;
    logic nonempty;
    logic server_free;
    logic has_room;
  } dp_stat_t;

endpackage

// ----- rtl/bqssu_ctrl.sv -----
// Controller state machine for the bounded queue server scheduler.
// Depends on bqssu_pkg; drives commands into bqssu_dp.
module bqssu_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  bqssu_pkg::dp_stat_t  stat,
  output bqssu_pkg::ctrl_cmd_t cmd
);
  import bqssu_pkg::*;

  fsm_state_t state_r, state_nxt;
  logic       pop_now;

  // A waiting request is served first when flushing or when the server is
  // already free by the time the new request arrives.
  assign pop_now = stat.nonempty && (stat.is_flush || stat.server_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = pop_now ? S_POP : S_FINAL;
      end
      S_POP: begin
        if (out_ready) state_nxt = S_DECIDE;
      end
      S_FINAL: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd.load  = 1'b0;
    cmd.pop   = 1'b0;
    cmd.fin   = 1'b0;
    cmd.kind  = ST_COMPLETED;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_DECIDE: begin
        if (pop_now) begin
          cmd.pop = 1'b1;
        end else begin
          cmd.fin = 1'b1;
          if (stat.is_flush)         cmd.kind = ST_FLUSH_DONE;
          else if (stat.server_free) cmd.kind = ST_COMPLETED;
          else if (stat.has_room)    cmd.kind = ST_QUEUED;
          else                       cmd.kind = ST_REJECTED;
        end
      end
      S_POP:   out_valid = 1'b1;
      S_FINAL: out_valid = 1'b1;
      default: out_valid = 1'b0;
    endcase
  end

endmodule

// ----- rtl/bqssu_dp.sv -----
// Datapath for the bounded queue server scheduler: wait queue memory,
// server clock, numbering and the output word register. Depends on bqssu_pkg.
module bqssu_dp #(
  parameter int QUEUE_DEPTH = bqssu_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bqssu_pkg::LIM_W-1:0]       cfg_data,
  input  logic                              in_func,
  input  logic [bqssu_pkg::TIME_W-1:0]      in_arrival_time,
  input  logic [bqssu_pkg::DUR_W-1:0]       in_duration,
  input  bqssu_pkg::ctrl_cmd_t              cmd,
  output bqssu_pkg::dp_stat_t               stat,
  output logic [bqssu_pkg::NUM_W-1:0]       out_request_number,
  output logic [1:0]                        out_status,
  output logic [bqssu_pkg::TIME_W-1:0]      out_end_time,
  output logic                              out_last
);
  import bqssu_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > LIM_W) ? CNT_W : LIM_W;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(QUEUE_DEPTH);

  wait_entry_t          mem [QUEUE_DEPTH];
  wait_entry_t          rd_r;
  wait_entry_t          wr_entry;
  logic                 we;

  logic [LIM_W-1:0]     limit_r;
  logic [TIME_W-1:0]    sft_r;
  logic [PTR_W-1:0]     head_r, tail_r;
  logic [CNT_W-1:0]     count_r;
  logic [NUM_W-1:0]     next_num_r;

  logic                 func_r;
  logic [TIME_W-1:0]    t_r;
  logic [DUR_W-1:0]     d_r;
  logic [NUM_W-1:0]     num_r;

  logic [TIME_W-1:0]    serve_arr, serve_start, serve_end;
  logic [DUR_W-1:0]     serve_dur;
  logic [TIME_W:0]      serve_sum;
  logic [CMP_W-1:0]     limit_cmp, cap;

  // Service start is the later of the server clock and the arrival; the end
  // time saturates instead of wrapping.
  always_comb begin
    serve_arr   = cmd.pop ? rd_r.arrival  : t_r;
    serve_dur   = cmd.pop ? rd_r.duration : d_r;
    serve_start = (sft_r > serve_arr) ? sft_r : serve_arr;
    serve_sum   = {1'b0, serve_start} + {(TIME_W + 1 - DUR_W)'(0), serve_dur};
    serve_end   = serve_sum[TIME_W] ? {TIME_W{1'b1}} : serve_sum[TIME_W-1:0];
  end

  always_comb begin
    limit_cmp = CMP_W'(limit_r);
    cap       = (limit_cmp < DEPTH_CMP) ? limit_cmp : DEPTH_CMP;
  end

  assign stat.is_flush    = func_r;
  assign stat.nonempty    = (count_r != '0);
  assign stat.server_free = (sft_r <= t_r);
  assign stat.has_room    = (CMP_W'(count_r) < cap);

  assign we                = cmd.fin && (cmd.kind == ST_QUEUED);
  assign wr_entry.arrival  = t_r;
  assign wr_entry.duration = d_r;
  assign wr_entry.number   = num_r;

  always_ff @(posedge clk) begin
    if (we) mem[tail_r] <= wr_entry;
    rd_r <= mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r    <= LIMIT_RESET;
      sft_r      <= '0;
      head_r     <= '0;
      tail_r     <= '0;
      count_r    <= '0;
      next_num_r <= '0;
    end else begin
      if (cfg_we) limit_r <= cfg_data;
      if (cmd.load && !in_func) next_num_r <= next_num_r + NUM_W'(1);
      if (cmd.pop) begin
        sft_r   <= serve_end;
        head_r  <= (head_r == LAST_PTR) ? '0 : head_r + PTR_W'(1);
        count_r <= count_r - CNT_W'(1);
      end
      if (cmd.fin && (cmd.kind == ST_COMPLETED)) sft_r <= serve_end;
      if (we) begin
        tail_r  <= (tail_r == LAST_PTR) ? '0 : tail_r + PTR_W'(1);
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  // Item and output word registers carry payload only.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      t_r    <= in_arrival_time;
      d_r    <= in_duration;
      num_r  <= next_num_r;
    end
    if (cmd.pop) begin
      out_request_number <= rd_r.number;
      out_status         <= ST_COMPLETED;
      out_end_time       <= serve_end;
      out_last           <= 1'b0;
    end else if (cmd.fin) begin
      out_status <= cmd.kind;
      out_last   <= 1'b1;
      case (cmd.kind)
        ST_COMPLETED: begin
          out_request_number <= num_r;
          out_end_time       <= serve_end;
        end
        ST_FLUSH_DONE: begin
          out_request_number <= '0;
          out_end_time       <= '0;
        end
        default: begin
          out_request_number <= num_r;
          out_end_time       <= '0;
        end
      endcase
    end
  end

endmodule

// ----- rtl/bounded_queue_server_scheduler_unit.sv -----
// Bounded queue server scheduler: single server with a FIFO of waiting
// requests, a controller (bqssu_ctrl) and a datapath (bqssu_dp).
// Input channel in_*: func 0 is a new request, func 1 a flush.
// Output channel out_*: one word per record; out_last marks the final word
// caused by an input word. Config channel cfg_*: writes queue_limit.
// One input word is taken at a time; in_ready is high only while idle.
// Each served waiting request passes through a decision state and then an
// output state that holds the registered word; the final record of a word
// takes the same two states. After acceptance the decision state comes first,
// and the first output word is valid in the output state that follows it.
// While out_ready is low the output word is held and no further work is
// done; the block resumes on the cycle after the word is taken.
// Reset (rst_n low at a clock edge) empties the queue, sets the server
// clock and request numbering to zero and queue_limit to 16; no clearing
// pass is needed. cfg_ready is always high.
module bounded_queue_server_scheduler_unit #(
  parameter int QUEUE_DEPTH = bqssu_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bqssu_pkg::LIM_W-1:0]      cfg_queue_limit,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_func,
  input  logic [bqssu_pkg::TIME_W-1:0]     in_arrival_time,
  input  logic [bqssu_pkg::DUR_W-1:0]      in_duration,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bqssu_pkg::NUM_W-1:0]      out_request_number,
  output logic [1:0]                       out_status,
  output logic [bqssu_pkg::TIME_W-1:0]     out_end_time,
  output logic                             out_last
);
  import bqssu_pkg::*;

  `include "bounded_queue_server_scheduler_unit_assert.svh"

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  bqssu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bqssu_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_data           (cfg_queue_limit),
    .in_func            (in_func),
    .in_arrival_time    (in_arrival_time),
    .in_duration        (in_duration),
    .cmd                (cmd),
    .stat               (stat),
    .out_request_number (out_request_number),
    .out_status         (out_status),
    .out_end_time       (out_end_time),
    .out_last           (out_last)
  );

  `BQSSU_ASSERT_SAME(a_one_side, in_ready, !out_valid, "input taken while a word is pending")
  `BQSSU_ASSERT_NEXT(a_idle_after_last, out_valid && out_ready && out_last, in_ready,
    "block not idle after the final word")
  `BQSSU_ASSERT_SAME(a_pop_completes, out_valid && !out_last,
    out_status == ST_COMPLETED, "non-final word is not a completion")
  `BQSSU_ASSERT_SAME(a_reject_final, out_valid && (out_status == ST_REJECTED),
    out_last && (out_end_time == '0), "rejection not a final word with zero end time")

endmodule
